FILE: rtl/tts_pkg.sv
package tts_pkg;

  // Field widths
  localparam int unsigned CoordW = 8;
  localparam int unsigned FracW  = 13;   // 1.12 fraction, 0..0x1000
  localparam int unsigned StateW = 12;
  localparam int unsigned OutW   = 11;

  // Screen and fraction constants
  localparam logic [CoordW-1:0] Y_MAX     = 8'd191;
  localparam logic [FracW-1:0]  FRAC_ONE  = 13'h1000;
  localparam logic [FracW-1:0]  FRAC_HALF = 13'h0800;

  // Target slopes (signed 1.12 gains)
  localparam logic signed [12:0] K_ONE_RIGHT = -13'sd256;
  localparam logic signed [12:0] K_TWO_RIGHT = -13'sd608;
  localparam logic signed [12:0] K_ONE_LEFT  = 13'sd608;
  localparam logic signed [12:0] K_TWO_LEFT  = 13'sd256;
  localparam logic signed [12:0] K_DEPTH_LO  = 13'sd32;
  localparam logic signed [12:0] K_DEPTH_HI  = 13'sd1280;
  localparam logic signed [12:0] K_DECAY     = 13'sd3584;

  // Reciprocal of 3, exact for 16-bit dividends
  localparam logic [16:0] RECIP_3 = 17'd43691;

  // One classified request between front and back
  typedef struct packed {
    logic                      touch;
    logic signed [StateW-1:0]  tgt_one;
    logic signed [StateW-1:0]  tgt_two;
    logic signed [StateW-1:0]  tgt_depth;
  } target_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic    avail;
    target_t head;
  } queue_out_t;

  // Round (p * k + 0x800) >> 12 with a flooring shift
  function automatic logic signed [StateW-1:0] mul_round(
    input logic signed [13:0] p,
    input logic signed [12:0] k
  );
    logic signed [26:0] prod;
    prod = 27'(p) * 27'(k) + 27'sd2048;
    return prod[23:12];
  endfunction

endpackage

FILE: rtl/tts_front.sv
module tts_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    touch_i,
  input  logic [7:0]              x_i,
  input  logic [7:0]              y_i,
  output logic                    push_o,
  output tts_pkg::target_t        push_data_o,
  input  logic                    full_i
);
  import tts_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_touch_q;
  logic [FracW-1:0]  qx_q, qx_d;
  logic [FracW-1:0]  ry_q, ry_d;
  logic              load;

  logic [11:0]       x_sh;
  logic [FracW-1:0]  x_sum;
  logic [7:0]        y_sat;
  logic [13:0]       y_sh;
  logic [30:0]       y_prod;

  logic              right;
  logic [FracW-1:0]  span;
  logic [FracW-1:0]  wy;
  logic signed [12:0] k_one, k_two;

  // Scale X: 4096x/255 = 16x + floor(16x/255)
  always_comb begin
    x_sh  = {x_i, 4'b0000};
    x_sum = 13'(x_sh) + 13'(x_sh >> 8) + 13'd1;
    qx_d  = 13'(x_sh) + 13'(x_sum[12:8]);
  end

  // Scale Y: clamp, then 4096y/192 = floor(64y/3) by reciprocal
  always_comb begin
    y_sat  = (y_i > Y_MAX) ? Y_MAX : y_i;
    y_sh   = {y_sat, 6'b000000};
    y_prod = 31'(y_sh) * 31'(RECIP_3);
    ry_d   = y_prod[29:17];
  end

  // Advance the scale stage when the queue can take its request
  assign in_ready_o = !s1_valid_q || !full_i;
  assign load       = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !full_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_touch_q <= touch_i;
      qx_q       <= qx_d;
      ry_q       <= ry_d;
    end
  end

  // Classify side of center and form the three targets
  always_comb begin
    right = qx_q > FRAC_HALF;
    if (right) begin
      span  = 13'(qx_q - FRAC_HALF) << 1;
      k_one = K_ONE_RIGHT;
      k_two = K_TWO_RIGHT;
    end else begin
      span  = 13'(FRAC_HALF - qx_q) << 1;
      k_one = K_ONE_LEFT;
      k_two = K_TWO_LEFT;
    end
    wy = FRAC_ONE - ry_q;
    push_data_o.touch     = s1_touch_q;
    push_data_o.tgt_one   = mul_round(signed'({1'b0, span}), k_one);
    push_data_o.tgt_two   = mul_round(signed'({1'b0, span}), k_two);
    push_data_o.tgt_depth = mul_round(signed'({1'b0, ry_q}), K_DEPTH_LO)
                          + mul_round(signed'({1'b0, wy}), K_DEPTH_HI);
  end

endmodule

FILE: rtl/tts_queue.sv
module tts_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tts_pkg::target_t      push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output tts_pkg::queue_out_t   q_o
);
  import tts_pkg::*;

  target_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign q_o.avail  = count_q != 2'd0;
  assign q_o.head   = mem_q[rd_ptr_q];

  // Write the request at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Track fill level
  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue fill level out of range");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("queue popped while empty");

endmodule

FILE: rtl/tts_back.sv
module tts_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tts_pkg::queue_out_t   q_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [10:0]    tilt_first_o,
  output logic [10:0]           depth_first_o,
  output logic signed [10:0]    tilt_second_o,
  output logic [10:0]           depth_second_o
);
  import tts_pkg::*;

  logic                     out_valid_q, out_valid_d;
  logic signed [StateW-1:0] tilt_one_q, tilt_one_d;
  logic signed [StateW-1:0] depth_one_q, depth_one_d;
  logic signed [StateW-1:0] tilt_two_q, tilt_two_d;
  logic signed [StateW-1:0] depth_two_q, depth_two_d;

  // Move a quarter of the way toward the target, flooring
  function automatic logic signed [StateW-1:0] approach(
    input logic signed [StateW-1:0] v,
    input logic signed [StateW-1:0] t
  );
    logic signed [StateW:0] diff;
    diff = 13'(t) - 13'(v);
    return v + 12'(diff >>> 2);
  endfunction

  // Take the next request once the output slot is free or being drained
  assign pop_o = q_i.avail && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Update all four values: approach on touch, decay otherwise
  always_comb begin
    tilt_one_d  = tilt_one_q;
    depth_one_d = depth_one_q;
    tilt_two_d  = tilt_two_q;
    depth_two_d = depth_two_q;
    if (pop_o) begin
      if (q_i.head.touch) begin
        tilt_one_d  = approach(tilt_one_q,  q_i.head.tgt_one);
        tilt_two_d  = approach(tilt_two_q,  q_i.head.tgt_two);
        depth_one_d = approach(depth_one_q, q_i.head.tgt_depth);
        depth_two_d = approach(depth_two_q, q_i.head.tgt_depth);
      end else begin
        tilt_one_d  = mul_round(14'(tilt_one_q),  K_DECAY);
        tilt_two_d  = mul_round(14'(tilt_two_q),  K_DECAY);
        depth_one_d = mul_round(14'(depth_one_q), K_DECAY);
        depth_two_d = mul_round(14'(depth_two_q), K_DECAY);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tilt_one_q  <= '0;
      depth_one_q <= '0;
      tilt_two_q  <= '0;
      depth_two_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      tilt_one_q  <= tilt_one_d;
      depth_one_q <= depth_one_d;
      tilt_two_q  <= tilt_two_d;
      depth_two_q <= depth_two_d;
    end
  end

  // The state registers double as the output register
  assign out_valid_o    = out_valid_q;
  assign tilt_first_o   = tilt_one_q[OutW-1:0];
  assign depth_first_o  = depth_one_q[OutW-1:0];
  assign tilt_second_o  = tilt_two_q[OutW-1:0];
  assign depth_second_o = depth_two_q[OutW-1:0];

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(tilt_one_q) && $stable(depth_one_q)
      && $stable(tilt_two_q) && $stable(depth_two_q))
    else $error("result changed while stalled");

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_one_q >= 12'sd0 && depth_one_q <= 12'sd1280
      && depth_two_q >= 12'sd0 && depth_two_q <= 12'sd1280)
    else $error("depth left its range");

endmodule

FILE: rtl/touch_tilt_smoother.sv
// Channel  Dir  Signals                              Contents (low bit up)
// s_axis   in   tvalid, tready, tdata[15:0], tuser   tdata: touch_x, touch_y; tuser: touch_valid
// m_axis   out  tvalid, tready, tdata[47:0]          tdata: tilt_first, depth_first,
//                                                    tilt_second, depth_second, zero fill
//
// One request per cycle sustained while m_axis is ready; a result is offered once its request
// has passed the scale stage, two-entry target queue and state update in the output register.
// The four state values update together, so the state loop sets the one-per-cycle rate.
// rst_ni clears the state values to zero and empties the pipeline at once.
// A stalled output holds its result; the queue keeps the input side taking requests
// until both queue entries and the scale stage are occupied.
module touch_tilt_smoother (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] touch_x, [15:8] touch_y
  input  logic        s_axis_tuser_i,   // [0] touch_valid
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // [10:0] tilt_first, [21:11] depth_first,
                                        // [32:22] tilt_second, [43:33] depth_second
);
  import tts_pkg::*;

  logic              push;
  target_t           push_data;
  logic              full;
  logic              pop;
  queue_out_t        q_out;
  logic signed [10:0] tilt_first, tilt_second;
  logic [10:0]       depth_first, depth_second;

  tts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .touch_i     (s_axis_tuser_i),
    .x_i         (s_axis_tdata_i[7:0]),
    .y_i         (s_axis_tdata_i[15:8]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  tts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .q_o         (q_out)
  );

  tts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q_out),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .tilt_first_o   (tilt_first),
    .depth_first_o  (depth_first),
    .tilt_second_o  (tilt_second),
    .depth_second_o (depth_second)
  );

  // Pack the result, zero fill to whole bytes
  assign m_axis_tdata_o = {4'b0000, depth_second, tilt_second, depth_first, tilt_first};

endmodule

FILE: verif/tb.sv
module tb;
  import tts_pkg::*;

  // Run limits and stall windows, in clock cycles
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned HoldAt     = 300;
  localparam int unsigned HoldLen    = 150;
  localparam int unsigned CalmFrom   = 700;
  localparam int unsigned CalmTo     = 1000;
  localparam int unsigned IdlePct    = 12;
  localparam int unsigned RandItems  = 1400;
  localparam int unsigned DrainWait  = 10;

  typedef struct packed {
    logic              valid;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } touch_t;

  // Highest field first, so tilt_first sits in the lowest bits
  typedef struct packed {
    logic [OutW-1:0] depth_second;
    logic [OutW-1:0] tilt_second;
    logic [OutW-1:0] depth_first;
    logic [OutW-1:0] tilt_first;
  } view_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;   // [7:0] touch_x, [15:8] touch_y
  logic        s_axis_tuser_i = 1'b0; // [0] touch_valid
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;        // [10:0] tilt_first, [21:11] depth_first,
                                      // [32:22] tilt_second, [43:33] depth_second

  touch_t touch_pending[$];
  view_t  view_q[$];
  int unsigned cyc = 0;
  int unsigned touches_taken = 0;
  int unsigned touch_total = 0;
  int unsigned fail_n = 0;
  int unsigned hold_left = 0;

  // Smoothed state as the block should hold it
  logic signed [StateW-1:0] tilt_a = '0;
  logic signed [StateW-1:0] depth_a = '0;
  logic signed [StateW-1:0] tilt_b = '0;
  logic signed [StateW-1:0] depth_b = '0;

  touch_tilt_smoother DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // (p * k + 0x800) >> 12, flooring
  function automatic int gain_round(int p, int k);
    return (p * k + 32'sh800) >>> 12;
  endfunction

  // Move a quarter of the way toward the target, flooring
  function automatic int glide(int v, int t);
    return v + ((t - v) >>> 2);
  endfunction

  // Advance the smoothed state by one touch sample and return the new view
  function automatic view_t smooth_touch(touch_t t);
    int   qx, ry, span, aim_a, aim_b, aim_d, yc;
    view_t v;
    if (t.valid) begin
      yc = (t.y > Y_MAX) ? int'(Y_MAX) : int'(t.y);
      qx = (int'(t.x) << 12) / 255;
      ry = (yc << 12) / 192;
      if (qx > 'h800) begin
        span  = (qx - 'h800) * 2;
        aim_a = gain_round(span, -'h100);
        aim_b = gain_round(span, -'h260);
      end else begin
        span  = ('h800 - qx) * 2;
        aim_a = gain_round(span, 'h260);
        aim_b = gain_round(span, 'h100);
      end
      aim_d   = gain_round(ry, 'h20) + gain_round('h1000 - ry, 'h500);
      tilt_a  = StateW'(glide(int'(tilt_a), aim_a));
      tilt_b  = StateW'(glide(int'(tilt_b), aim_b));
      depth_a = StateW'(glide(int'(depth_a), aim_d));
      depth_b = StateW'(glide(int'(depth_b), aim_d));
    end else begin
      tilt_a  = StateW'(gain_round(int'(tilt_a), 'hE00));
      depth_a = StateW'(gain_round(int'(depth_a), 'hE00));
      tilt_b  = StateW'(gain_round(int'(tilt_b), 'hE00));
      depth_b = StateW'(gain_round(int'(depth_b), 'hE00));
    end
    v.tilt_first   = tilt_a[OutW-1:0];
    v.depth_first  = depth_a[OutW-1:0];
    v.tilt_second  = tilt_b[OutW-1:0];
    v.depth_second = depth_b[OutW-1:0];
    return v;
  endfunction

  task automatic add_touch(logic valid, int x, int y);
    touch_t t;
    t.valid = valid;
    t.x     = CoordW'(x);
    t.y     = CoordW'(y);
    touch_pending.push_back(t);
  endtask

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Drive touch requests and predict the view for each one taken
  always @(posedge clk_i) begin
    touch_t t;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        t.valid = s_axis_tuser_i;
        t.x     = s_axis_tdata_i[7:0];
        t.y     = s_axis_tdata_i[15:8];
        view_q.push_back(smooth_touch(t));
        touches_taken <= touches_taken + 1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (touch_pending.size() > 0 &&
            ((cyc >= CalmFrom && cyc < CalmTo) || $urandom_range(99) >= IdlePct)) begin
          t = touch_pending.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {t.y, t.x};
          s_axis_tuser_i  <= t.valid;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Drive ready: random stalls, one long hold-off, one calm stretch
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (cyc == HoldAt) hold_left = HoldLen;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (cyc >= CalmFrom && cyc < CalmTo) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Check each view taken against the oldest prediction
  always @(posedge clk_i) begin
    view_t want, got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[4*OutW-1:0];
      if (view_q.size() == 0) begin
        $error("unexpected view 0x%h", m_axis_tdata_o);
        fail_n++;
      end else begin
        want = view_q.pop_front();
        if (got.tilt_first != want.tilt_first) begin
          $error("tilt_first: expected %0d, got %0d",
                 $signed(want.tilt_first), $signed(got.tilt_first));
          fail_n++;
        end
        if (got.depth_first != want.depth_first) begin
          $error("depth_first: expected %0d, got %0d", want.depth_first, got.depth_first);
          fail_n++;
        end
        if (got.tilt_second != want.tilt_second) begin
          $error("tilt_second: expected %0d, got %0d",
                 $signed(want.tilt_second), $signed(got.tilt_second));
          fail_n++;
        end
        if (got.depth_second != want.depth_second) begin
          $error("depth_second: expected %0d, got %0d", want.depth_second, got.depth_second);
          fail_n++;
        end
        if (m_axis_tdata_o[47:4*OutW] != '0) begin
          $error("zero_fill: expected 0, got 0x%h", m_axis_tdata_o[47:4*OutW]);
          fail_n++;
        end
      end
    end
  end

  // Build the stimulus, release reset, drain and report
  initial begin
    int n, len, kind, x, y, k;

    // Corners of the screen, both sides of center, Y past its range
    add_touch(1'b1, 0, 0);
    add_touch(1'b1, 0, 191);
    add_touch(1'b1, 255, 0);
    add_touch(1'b1, 255, 191);
    add_touch(1'b1, 127, 96);
    add_touch(1'b1, 128, 96);
    add_touch(1'b1, 0, 192);
    add_touch(1'b1, 0, 255);
    for (k = 0; k < 3; k++) add_touch(1'b1, 0, 0);
    // Decay a positive tilt; coordinates must not matter
    add_touch(1'b0, 255, 255);
    add_touch(1'b0, 0, 0);
    add_touch(1'b0, 170, 85);
    // Swing to the right edge, then decay a negative tilt
    for (k = 0; k < 4; k++) add_touch(1'b1, 255, 255);
    for (k = 0; k < 4; k++) add_touch(1'b0, 85, 170);
    add_touch(1'b1, 128, 191);
    add_touch(1'b1, 127, 0);

    // Random runs: mostly touch strokes, some release periods
    n = 0;
    while (n < RandItems) begin
      kind = $urandom_range(99);
      len  = (kind < 75) ? $urandom_range(1, 30) : $urandom_range(1, 20);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(9))
          0: x = $urandom_range(1) ? 255 : 0;
          1: x = $urandom_range(120, 135);
          default: x = $urandom_range(255);
        endcase
        y = ($urandom_range(9) == 0) ? $urandom_range(192, 255) : $urandom_range(191);
        add_touch(kind < 75, x, y);
      end
      n += len;
    end
    touch_total = touch_pending.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (touches_taken != touch_total) @(posedge clk_i);
    while (view_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (view_q.size() != 0) begin
      $error("%0d views never arrived", view_q.size());
      fail_n++;
    end
    if (fail_n == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
